FILE: hdl/smi_pkg.sv
// Package for the small matrix inverse block: job descriptor, sequencer states,
// widths and the permutation table used for determinant terms.
// No dependencies.
`default_nettype none
package smi_pkg;

    localparam int MAX_SIZE    = 4;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W      = 4;
    localparam int CNT_W       = 5;
    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 128;
    localparam int ACC_W       = 136;
    localparam int DIV_STEPS   = 136;
    localparam logic [2:0] NO_EXCL = 3'd4;

    // One queued matrix job: the clamped size
    typedef struct packed {
        logic [2:0] size;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FETCH,
        B_LOAD,
        B_MUL,
        B_ACC,
        B_DETFIN,
        B_MINOR,
        B_ABS,
        B_NUM,
        B_DIV,
        B_SAT,
        B_EMIT
    } back_state_t;

    // Number of permutation terms of an m x m determinant
    function automatic logic [4:0] fact(input logic [2:0] m);
        case (m)
            3'd1:    fact = 5'd1;
            3'd2:    fact = 5'd2;
            3'd3:    fact = 5'd6;
            default: fact = 5'd24;
        endcase
    endfunction

    // Permutations of four ordered so that the first m! of them permute only
    // the first m positions. Result: {odd parity, p3, p2, p1, p0}.
    function automatic logic [8:0] perm_entry(input logic [4:0] k);
        case (k)
            5'd0:    perm_entry = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            5'd1:    perm_entry = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd2:    perm_entry = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd3:    perm_entry = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd4:    perm_entry = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd5:    perm_entry = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd6:    perm_entry = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd7:    perm_entry = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd8:    perm_entry = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            5'd9:    perm_entry = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd10:   perm_entry = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd11:   perm_entry = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd12:   perm_entry = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd13:   perm_entry = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd14:   perm_entry = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd15:   perm_entry = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd16:   perm_entry = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd17:   perm_entry = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd18:   perm_entry = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd19:   perm_entry = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd20:   perm_entry = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd21:   perm_entry = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd22:   perm_entry = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            default: perm_entry = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hdl/smi_front.sv
// Front end: accepts matrix elements, keeps them in the element store and
// queues a job on the last element. Depends on smi_pkg.
`default_nettype none
module smi_front import smi_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic              s_tlast,
    input  wire logic [2:0]        size_cfg,
    output logic                   push,
    output job_t                   push_job,
    input  wire logic              done,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [ELEM_W-1:0]      rd_data
);

    logic [ELEM_W-1:0] store [STORE_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hold_reg, hold_next;
    logic              accept;

    assign s_tready = !hold_reg;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;

    // Clamp the size at the moment the job is queued
    always_comb begin
        if (size_cfg < 3'd2) begin
            push_job.size = 3'd2;
        end else if (size_cfg > 3'(MAX_SIZE)) begin
            push_job.size = 3'(MAX_SIZE);
        end else begin
            push_job.size = size_cfg;
        end
    end

    // Count elements, hold off input until the job is finished
    always_comb begin
        count_next = count_reg;
        hold_next  = hold_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next = '0;
                hold_next  = 1'b1;
            end else if (count_reg < CNT_W'(STORE_DEPTH)) begin
                count_next = count_reg + 1'b1;
            end
        end
        if (done) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hold_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

    // Element store: write on transfer, registered read for the back end
    always_ff @(posedge aclk) begin
        if (accept && count_reg < CNT_W'(STORE_DEPTH)) begin
            store[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        rd_data <= store[rd_addr];
    end

endmodule
`default_nettype wire

FILE: hdl/smi_job_fifo.sv
// Two-entry queue of matrix jobs between front and back end.
// Depends on smi_pkg.
`default_nettype none
module smi_job_fifo import smi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign not_empty = fill_reg != 2'd0;
    assign head_job  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push && fill_reg != 2'd2) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && fill_reg != 2'd2) && !(pop && not_empty)) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (!(push && fill_reg != 2'd2) && (pop && not_empty)) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && fill_reg != 2'd2) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/smi_back.sv
// Back end: determinant and signed minors by permutation terms on a shared
// 32x32 multiplier, restoring divider, saturation and the result register.
// Depends on smi_pkg.
`default_nettype none
module smi_back import smi_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    input  wire job_t              job,
    output logic                   job_pop,
    output logic                   done,
    output logic [ADDR_W-1:0]      rd_addr,
    input  wire logic [ELEM_W-1:0] rd_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    back_state_t       state_reg, state_next;
    logic [2:0]        n_reg, n_next;
    logic [2:0]        m_reg, m_next;
    logic [2:0]        exr_reg, exr_next;
    logic [2:0]        exc_reg, exc_next;
    logic [4:0]        k_reg, k_next;
    logic [1:0]        r_reg, r_next;
    logic [1:0]        limb_reg, limb_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic              s_reg, s_next;
    logic [31:0]       em_reg, em_next;
    logic [31:0]       carry_reg, carry_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  dmag_reg, dmag_next;
    logic              det_neg_reg, det_neg_next;
    logic              sing_reg, sing_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [31:0]       qlo_reg, qlo_next;
    logic              big_reg, big_next;
    logic [7:0]        step_reg, step_next;
    logic [1:0]        i_reg, i_next;
    logic [1:0]        j_reg, j_next;
    logic [31:0]       val_reg, val_next;
    logic              sat_reg, sat_next;
    logic              ov_reg, ov_next;
    logic [31:0]       ov_val_reg, ov_val_next;
    logic [1:0]        ov_row_reg, ov_row_next;
    logic [1:0]        ov_col_reg, ov_col_next;
    logic              ov_sing_reg, ov_sing_next;
    logic              ov_sat_reg, ov_sat_next;
    logic              ov_last_reg, ov_last_next;

    logic [8:0]        perm;
    logic [1:0]        pcol;
    logic [2:0]        row_idx, col_idx;
    logic [3:0]        row_base;
    logic              e_neg;
    logic [31:0]       e_mag;
    logic [63:0]       mac;
    logic              term_neg;
    logic [ACC_W-1:0]  p_ext;
    logic              r_last, k_last, ij_last, out_free;
    logic [ACC_W:0]    trial;
    logic [ACC_W:0]    div_diff;
    logic [31:0]       limit;
    logic              over;

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, ov_col_reg, ov_row_reg, ov_val_reg};
    assign m_tuser  = {ov_sat_reg, ov_sing_reg};
    assign m_tlast  = ov_last_reg;

    // Map minor position to store address
    always_comb begin
        perm     = perm_entry(k_reg);
        case (r_reg)
            2'd0:    pcol = perm[1:0];
            2'd1:    pcol = perm[3:2];
            2'd2:    pcol = perm[5:4];
            default: pcol = perm[7:6];
        endcase
        row_idx  = {1'b0, r_reg} + (({1'b0, r_reg} >= exr_reg) ? 3'd1 : 3'd0);
        col_idx  = {1'b0, pcol} + (({1'b0, pcol} >= exc_reg) ? 3'd1 : 3'd0);
        case (n_reg)
            3'd2:    row_base = {row_idx[2:0], 1'b0};
            3'd3:    row_base = {row_idx[2:0], 1'b0} + {1'b0, row_idx};
            default: row_base = {row_idx[1:0], 2'b00};
        endcase
        rd_addr  = row_base + {1'b0, col_idx};
    end

    // Shared datapath terms
    always_comb begin
        e_neg    = rd_data[31];
        e_mag    = e_neg ? (32'd0 - rd_data) : rd_data;
        mac      = 64'(p_reg[31:0]) * 64'(em_reg) + 64'(carry_reg);
        term_neg = s_reg ^ perm[8];
        p_ext    = {{(ACC_W-PROD_W){1'b0}}, p_reg};
        r_last   = {1'b0, r_reg} == (m_reg - 3'd1);
        k_last   = k_reg == (fact(m_reg) - 5'd1);
        ij_last  = ({1'b0, i_reg} == n_reg - 3'd1) && ({1'b0, j_reg} == n_reg - 3'd1);
        out_free = !ov_reg || m_tready;
        trial    = {rem_reg, num_reg[ACC_W-1]};
        div_diff = trial - {dmag_reg, 1'b0};
        limit    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        over     = big_reg || (qlo_reg > limit);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (job_valid) state_next = B_FETCH;
            B_FETCH:  state_next = B_LOAD;
            B_LOAD: begin
                if (r_reg != 2'd0) begin
                    state_next = B_MUL;
                end else if (r_last) begin
                    state_next = B_ACC;
                end else begin
                    state_next = B_FETCH;
                end
            end
            B_MUL: begin
                if (limb_reg == 2'd3) begin
                    state_next = r_last ? B_ACC : B_FETCH;
                end
            end
            B_ACC: begin
                if (!k_last) begin
                    state_next = B_FETCH;
                end else if (exr_reg == NO_EXCL) begin
                    state_next = B_DETFIN;
                end else begin
                    state_next = B_ABS;
                end
            end
            B_DETFIN: state_next = (acc_reg == '0) ? B_EMIT : B_MINOR;
            B_MINOR:  state_next = B_FETCH;
            B_ABS:    state_next = B_NUM;
            B_NUM:    state_next = B_DIV;
            B_DIV:    if (step_reg == 8'(DIV_STEPS - 1)) state_next = B_SAT;
            B_SAT:    state_next = B_EMIT;
            B_EMIT: begin
                if (out_free) begin
                    if (ij_last) begin
                        state_next = B_IDLE;
                    end else if (sing_reg) begin
                        state_next = B_EMIT;
                    end else begin
                        state_next = B_MINOR;
                    end
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_next       = n_reg;
        m_next       = m_reg;
        exr_next     = exr_reg;
        exc_next     = exc_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        limb_next    = limb_reg;
        p_next       = p_reg;
        s_next       = s_reg;
        em_next      = em_reg;
        carry_next   = carry_reg;
        acc_next     = acc_reg;
        dmag_next    = dmag_reg;
        det_neg_next = det_neg_reg;
        sing_next    = sing_reg;
        neg_next     = neg_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        qlo_next     = qlo_reg;
        big_next     = big_reg;
        step_next    = step_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        val_next     = val_reg;
        sat_next     = sat_reg;
        ov_next      = ov_reg && !m_tready;
        ov_val_next  = ov_val_reg;
        ov_row_next  = ov_row_reg;
        ov_col_next  = ov_col_reg;
        ov_sing_next = ov_sing_reg;
        ov_sat_next  = ov_sat_reg;
        ov_last_next = ov_last_reg;
        job_pop      = 1'b0;
        done         = 1'b0;
        case (state_reg)
            // Take a job and start the full determinant
            B_IDLE: begin
                if (job_valid) begin
                    job_pop   = 1'b1;
                    n_next    = job.size;
                    m_next    = job.size;
                    exr_next  = NO_EXCL;
                    exc_next  = NO_EXCL;
                    k_next    = '0;
                    r_next    = '0;
                    acc_next  = '0;
                    i_next    = '0;
                    j_next    = '0;
                    sing_next = 1'b0;
                end
            end
            B_FETCH: begin
            end
            // First factor loads the product, later ones start a multiply
            B_LOAD: begin
                if (r_reg == 2'd0) begin
                    p_next = {{(PROD_W-32){1'b0}}, e_mag};
                    s_next = e_neg;
                    if (!r_last) r_next = r_reg + 2'd1;
                end else begin
                    em_next    = e_mag;
                    s_next     = s_reg ^ e_neg;
                    limb_next  = '0;
                    carry_next = '0;
                end
            end
            // One 32-bit limb of the product per cycle
            B_MUL: begin
                p_next     = {mac[31:0], p_reg[PROD_W-1:32]};
                carry_next = mac[63:32];
                limb_next  = limb_reg + 2'd1;
                if (limb_reg == 2'd3 && !r_last) r_next = r_reg + 2'd1;
            end
            // Add the signed term
            B_ACC: begin
                acc_next = acc_reg + (term_neg ? ~p_ext : p_ext) + ACC_W'(term_neg);
                if (!k_last) begin
                    k_next = k_reg + 5'd1;
                    r_next = '0;
                end
            end
            // Determinant finished
            B_DETFIN: begin
                det_neg_next = acc_reg[ACC_W-1];
                dmag_next    = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
                if (acc_reg == '0) begin
                    sing_next = 1'b1;
                    val_next  = '0;
                    sat_next  = 1'b0;
                end
            end
            // Minor with row j and column i removed
            B_MINOR: begin
                m_next   = n_reg - 3'd1;
                exr_next = {1'b0, j_reg};
                exc_next = {1'b0, i_reg};
                k_next   = '0;
                r_next   = '0;
                acc_next = '0;
            end
            B_ABS: begin
                neg_next = acc_reg[ACC_W-1] ^ i_reg[0] ^ j_reg[0] ^ det_neg_reg;
                acc_next = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
            end
            // Numerator = |adj| * 2^33 + |det|, rounds half away from zero
            B_NUM: begin
                num_next  = {acc_reg[ACC_W-34:0], 33'd0} + dmag_reg;
                rem_next  = '0;
                qlo_next  = '0;
                big_next  = 1'b0;
                step_next = '0;
            end
            // One quotient bit per cycle
            B_DIV: begin
                num_next  = {num_reg[ACC_W-2:0], 1'b0};
                big_next  = big_reg | qlo_reg[31];
                if (!div_diff[ACC_W]) begin
                    rem_next = div_diff[ACC_W-1:0];
                    qlo_next = {qlo_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[ACC_W-1:0];
                    qlo_next = {qlo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 8'd1;
            end
            // Clip and apply the sign
            B_SAT: begin
                sat_next = over;
                val_next = neg_reg ? (32'd0 - (over ? limit : qlo_reg))
                                   : (over ? limit : qlo_reg);
            end
            // Hand the element to the result register
            B_EMIT: begin
                if (out_free) begin
                    ov_next      = 1'b1;
                    ov_val_next  = val_reg;
                    ov_row_next  = i_reg;
                    ov_col_next  = j_reg;
                    ov_sing_next = sing_reg;
                    ov_sat_next  = sat_reg;
                    ov_last_next = ij_last;
                    if (ij_last) begin
                        done = 1'b1;
                    end else if ({1'b0, j_reg} == n_reg - 3'd1) begin
                        j_next = '0;
                        i_next = i_reg + 2'd1;
                    end else begin
                        j_next = j_reg + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        m_reg       <= m_next;
        exr_reg     <= exr_next;
        exc_reg     <= exc_next;
        k_reg       <= k_next;
        r_reg       <= r_next;
        limb_reg    <= limb_next;
        p_reg       <= p_next;
        s_reg       <= s_next;
        em_reg      <= em_next;
        carry_reg   <= carry_next;
        acc_reg     <= acc_next;
        dmag_reg    <= dmag_next;
        det_neg_reg <= det_neg_next;
        sing_reg    <= sing_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        qlo_reg     <= qlo_next;
        big_reg     <= big_next;
        step_reg    <= step_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        val_reg     <= val_next;
        sat_reg     <= sat_next;
        ov_val_reg  <= ov_val_next;
        ov_row_reg  <= ov_row_next;
        ov_col_reg  <= ov_col_next;
        ov_sing_reg <= ov_sing_next;
        ov_sat_reg  <= ov_sat_next;
        ov_last_reg <= ov_last_next;
    end

endmodule
`default_nettype wire

FILE: hdl/small_matrix_inverse.sv
// Small matrix inverse: elements of an n x n Q16.16 matrix (n = 2..4) enter
// one per cycle in row-major order; the element with tlast starts the job and
// input stalls until the last inverse element has entered the result register.
// The determinant and, unless it is zero, every minor are summed over permutation
// terms; each term fetches its factors from the element store, multiplies them
// limb by limb on one 32x32 multiplier and is accumulated; each inverse element
// is then divided in the restoring divider, saturated and sent out.
// Depends on smi_pkg, smi_front, smi_job_fifo and smi_back.
`default_nettype none
module small_matrix_inverse import smi_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,     // matrix_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,      // element_value
    input  wire logic        s_tlast,      // last_element
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,      // inverse_value, out_row, out_col, pad
    output logic [1:0]       m_tuser,      // singular, saturated
    output logic             m_tlast       // last_result
);

    logic [2:0]        size_reg;
    logic              push, pop, not_empty, done;
    job_t              push_job, head_job;
    logic [ADDR_W-1:0] rd_addr;
    logic [ELEM_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    // Hold the configured size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 3'd3;
        end else if (cfg_valid && cfg_ready) begin
            size_reg <= cfg_data;
        end
    end

    smi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .size_cfg (size_reg),
        .push     (push),
        .push_job (push_job),
        .done     (done),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    smi_job_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    smi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (not_empty),
        .job       (head_job),
        .job_pop   (pop),
        .done      (done),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for small_matrix_inverse: streams Q16.16 matrices, predicts every
// inverse element with exact wide integer arithmetic and checks each transfer.
// Depends on smi_pkg and small_matrix_inverse.
`timescale 1ns / 100ps

typedef struct packed {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        singular;
    logic        saturated;
    logic        last;
} inv_elem_t;

class inverse_scoreboard;
    logic [31:0] elem_store [16];
    int          fill;
    logic [2:0]  size_reg;
    inv_elem_t   pending_q [$];
    int          errors;
    int          checked;
    int          matrices;

    function new();
        fill     = 0;
        size_reg = 3;
        errors   = 0;
        checked  = 0;
        matrices = 0;
    endfunction

    function void note_size(logic [2:0] v);
        size_reg = v;
    endfunction

    // Exact determinant of the n x n matrix with row xr and column xc removed
    // (4 removes nothing), summed over all permutations
    function logic signed [199:0] minor_det(int n, int xr, int xc);
        int rl [4];
        int cl [4];
        int d [4];
        int m, mc, k, j, idx, inv;
        bit ok;
        logic signed [199:0] sum, term;
        logic signed [31:0]  e;
        m  = 0;
        mc = 0;
        for (k = 0; k < n; k++) begin
            if (k != xr) begin
                rl[m] = k;
                m++;
            end
            if (k != xc) begin
                cl[mc] = k;
                mc++;
            end
        end
        sum = 0;
        for (idx = 0; idx < 256; idx++) begin
            ok = 1;
            for (k = 0; k < 4; k++) begin
                d[k] = (idx >> (2 * k)) & 3;
                if (k < m ? d[k] >= m : d[k] != 0) ok = 0;
            end
            for (k = 0; k < m; k++)
                for (j = 0; j < k; j++)
                    if (d[j] == d[k]) ok = 0;
            if (ok) begin
                inv  = 0;
                term = 1;
                for (k = 0; k < m; k++) begin
                    e    = elem_store[rl[k] * n + cl[d[k]]];
                    term = term * e;
                    for (j = k + 1; j < m; j++)
                        if (d[j] < d[k]) inv++;
                end
                sum = (inv % 2) ? sum - term : sum + term;
            end
        end
        return sum;
    endfunction

    // Queue all inverse elements of the matrix now in the store
    function void predict_inverse();
        int n, i, j;
        logic signed [199:0] det, adj;
        logic [199:0] dmag, amag, num, quot, limit;
        bit neg, sing;
        inv_elem_t r;
        n    = size_reg < 2 ? 2 : (size_reg > smi_pkg::MAX_SIZE ? smi_pkg::MAX_SIZE : size_reg);
        det  = minor_det(n, 4, 4);
        sing = (det == 0);
        dmag = det < 0 ? -det : det;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                r.value     = 0;
                r.saturated = 0;
                if (!sing) begin
                    adj = minor_det(n, j, i);
                    if ((i + j) % 2) adj = -adj;
                    neg   = (adj < 0) != (det < 0);
                    amag  = adj < 0 ? -adj : adj;
                    num   = (amag << 33) + dmag;
                    quot  = num / (dmag << 1);
                    limit = neg ? 200'h8000_0000 : 200'h7fff_ffff;
                    if (quot > limit) begin
                        r.saturated = 1;
                        quot        = limit;
                    end
                    r.value = neg ? -quot[31:0] : quot[31:0];
                end
                r.row      = i;
                r.col      = j;
                r.singular = sing;
                r.last     = (i == n - 1) && (j == n - 1);
                pending_q.push_back(r);
            end
        end
        matrices++;
    endfunction

    function void note_element(logic [31:0] v, logic last);
        if (fill < 16) begin
            elem_store[fill] = v;
            fill++;
        end
        if (last) begin
            predict_inverse();
            fill = 0;
        end
    endfunction

    function void check_result(inv_elem_t got);
        inv_elem_t want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result value %h row %0d col %0d",
                     $time, got.value, got.row, got.col);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        checked++;
        if (got != want) begin
            $display("%0t: mismatch expected val %h r %0d c %0d sing %b sat %b last %b",
                     $time, want.value, want.row, want.col, want.singular,
                     want.saturated, want.last);
            $display("%0t:          actual   val %h r %0d c %0d sing %b sat %b last %b",
                     $time, got.value, got.row, got.col, got.singular,
                     got.saturated, got.last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import smi_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    inverse_scoreboard sb;
    int  snd_idle;
    int  rcv_idle;
    bit  rcv_hold;
    int  items_sent;
    int  quiet_cycles = 0;
    logic [31:0] vals [20];

    small_matrix_inverse i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, or a long hold when asked
    always @(posedge aclk) begin
        m_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
    end

    // Watch all transfers: feed the scoreboard and count quiet cycles
    always @(posedge aclk) begin
        inv_elem_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.note_size(cfg_data);
            if (s_tvalid && s_tready) sb.note_element(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.value     = m_tdata[31:0];
                got.row       = m_tdata[33:32];
                got.col       = m_tdata[35:34];
                got.singular  = m_tuser[0];
                got.saturated = m_tuser[1];
                got.last      = m_tlast;
                sb.check_result(got);
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_element(logic [31:0] v, logic last);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Hold until every expected result is in, then let the block settle
    task automatic drain();
        stop_sending();
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [2:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value(int style);
        case (style)
            0:       return $urandom;
            1:       return ($urandom_range(0, 8) - 4) * 32'h1_0000 + $urandom_range(0, 16'hffff);
            2:       return $urandom_range(0, 6) - 3;
            default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
                            ^ $urandom_range(0, 3);
        endcase
    endfunction

    // One matrix: mostly well formed, sometimes cut short or overlong,
    // sometimes with two equal rows
    task automatic send_matrix(int n);
        int cnt, style, k;
        cnt   = n * n;
        style = $urandom_range(0, 9);
        case ($urandom_range(0, 19))
            0:       cnt = $urandom_range(1, n * n - 1);
            1:       cnt = $urandom_range(n * n + 1, 20);
            default: ;
        endcase
        for (k = 0; k < 20; k++) vals[k] = pick_value(style % 4);
        if (style >= 8)
            for (k = 0; k < n; k++) vals[n + k] = vals[k];
        for (k = 0; k < cnt; k++) send_element(vals[k], k == cnt - 1);
    endtask

    function automatic logic [2:0] pick_size();
        int w;
        w = $urandom_range(0, 9);
        if (w < 4) return 2;
        if (w < 7) return 3;
        if (w == 7) return 4;
        if (w == 8) return $urandom_range(0, 1);
        return $urandom_range(5, 7);
    endfunction

    task automatic random_until(int target);
        logic [2:0] sz;
        int n, k;
        while (items_sent < target) begin
            sz = pick_size();
            write_size(sz);
            n = sz < 2 ? 2 : (sz > MAX_SIZE ? MAX_SIZE : sz);
            for (k = 0; k < 4; k++) send_matrix(n);
        end
    endtask

    initial begin
        int k;
        sb           = new();
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 3'd0;
        s_tvalid     = 1'b0;
        s_tdata      = 32'd0;
        s_tlast      = 1'b0;
        rcv_hold     = 1'b0;
        snd_idle     = 7;
        rcv_idle     = 80;
        items_sent   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full 4x4 first so every store entry holds a written value
        write_size(3'd4);
        send_element(32'h8000_0000, 0);
        send_element(32'h7fff_ffff, 0);
        send_element(32'h0000_0000, 0);
        send_element(32'hffff_ffff, 0);
        for (k = 4; k < 15; k++) send_element($urandom, 0);
        send_element(32'h0000_0001, 1);
        // Raw identity of tiny values: inverse saturates
        write_size(3'd2);
        send_element(32'd1, 0);
        send_element(32'd0, 0);
        send_element(32'd0, 0);
        send_element(32'd1, 1);
        // Equal rows: singular
        send_element(32'h0001_0000, 0);
        send_element(32'h0002_0000, 0);
        send_element(32'h0001_0000, 0);
        send_element(32'h0002_0000, 1);
        // Size code below range, matrix cut short
        write_size(3'd0);
        send_element(32'h0003_0000, 0);
        send_element(32'hfffe_8000, 1);

        random_until(130);

        drain();
        snd_idle = 80;
        rcv_idle = 7;
        random_until(260);

        // No idling; receiver holds off while the sender keeps offering
        drain();
        snd_idle = 0;
        rcv_idle = 0;
        write_size(3'd2);
        fork
            begin
                rcv_hold = 1'b1;
                repeat (3000) @(posedge aclk);
                rcv_hold = 1'b0;
            end
            for (k = 0; k < 4; k++) send_matrix(2);
        join
        random_until(400);

        drain();
        $display("Run covered %0d matrices over all size codes, %0d inverse elements checked",
                 sb.matrices, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/smi_pkg.sv
hdl/smi_front.sv
hdl/smi_job_fifo.sv
hdl/smi_back.sv
hdl/small_matrix_inverse.sv
test/tb_top.sv
